// File: rtl/idlw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idlw_pkg
// Shared types, register codes and byte selection for the DAC level writer.
// ----------------------------------------------------------------------------
package idlw_pkg;

	localparam int unsigned LevelW = 12;
	localparam int unsigned WaitW  = 16;
	localparam int unsigned AddrW  = 4;
	localparam int unsigned DataW  = 32;

	localparam logic [7:0]        DevAddrRst = 8'h50;
	localparam logic [7:0]        CmdByteRst = 8'h2f;
	localparam logic [WaitW-1:0]  TimeoutRst = 16'd2000;

	typedef enum logic [1:0] {
		REG_DEV_ADDR = 2'd0,
		REG_CMD_BYTE = 2'd1,
		REG_TIMEOUT  = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef enum logic [3:0] {
		SEG_IDLE  = 4'd0,
		SEG_POLL  = 4'd1,
		SEG_START = 4'd2,
		SEG_BLO   = 4'd3,
		SEG_BHI   = 4'd4,
		SEG_ALO   = 4'd5,
		SEG_AHI   = 4'd6,
		SEG_AHOLD = 4'd7,
		SEG_P0    = 4'd8,
		SEG_P1    = 4'd9
	} seg_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_NOT_RDY = 2'd1,
		ST_NACK    = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0]       device_address;
		logic [7:0]       command_byte;
		logic [WaitW-1:0] ready_timeout;
	} cfg_t;

	typedef struct packed {
		logic [1:0] status;
		logic       done_res;
		logic       busy_res;
		logic       sda_out;
		logic       sda_oe;
		logic       scl;
	} res_t;

	function automatic logic [7:0] byte_for(input logic [1:0] n, input cfg_t cfg,
			input logic [LevelW-1:0] lvl);
		logic [7:0] b;
		case (n)
			2'd0:    b = cfg.device_address;
			2'd1:    b = cfg.command_byte;
			2'd2:    b = lvl[11:4];
			default: b = {lvl[3:0], 4'h0};
		endcase
		return b;
	endfunction

endpackage

// File: rtl/i2c_dac_level_writer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_dac_level_writer_core
// I2C master sequencer that writes a twelve-bit level to a DAC, one bus
// segment per tick word.
// ----------------------------------------------------------------------------
// Channel   Direction  Contents
// s_*       in         opcode in tuser; level, sda_in in tdata
// m_*       out        scl, sda_oe, sda_out, busy_res, done_res, status
// APB       in/out     device_address, command_byte, ready_timeout
//
// Each input word gives one result word on the cycle after it is taken.
// A new word is taken every cycle while the result register is empty or
// being drained, so a stalled m_tready holds the input side by one word.
// Reset clears the sequencer to idle and loads the register defaults.
// ----------------------------------------------------------------------------
module i2c_dac_level_writer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [15:0]                   s_tdata,  // level[11:0], sda_in[12], zero[15:13]
	input  logic                          s_tuser,  // opcode[0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,  // scl, sda_oe, sda_out, busy_res,
	                                                // done_res, status[6:5], zero[7]
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [idlw_pkg::AddrW-1:0]    paddr,
	input  logic [idlw_pkg::DataW-1:0]    pwdata,
	output logic [idlw_pkg::DataW-1:0]    prdata,
	output logic                          pready
);

	idlw_pkg::cfg_t cfg;
	idlw_pkg::res_t res;
	idlw_pkg::res_t res_q;
	logic           out_vld_q;
	logic           in_fire;

	assign s_tready = !out_vld_q || m_tready;
	assign in_fire  = s_tvalid && s_tready;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, res_q};

	idlw_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	idlw_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_fire),
		.opcode (s_tuser),
		.level  (s_tdata[11:0]),
		.sda_in (s_tdata[12]),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (in_fire) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_q <= res;
		end
	end

endmodule

// File: rtl/idlw_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idlw_cfg
// Register file behind the APB port: address, command byte and timeout.
// ----------------------------------------------------------------------------
module idlw_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [idlw_pkg::AddrW-1:0]    paddr,
	input  logic [idlw_pkg::DataW-1:0]    pwdata,
	output logic [idlw_pkg::DataW-1:0]    prdata,
	output logic                          pready,
	output idlw_pkg::cfg_t                cfg
);

	idlw_pkg::cfg_t     cfg_q;
	idlw_pkg::reg_idx_t idx;
	logic               wr_en;

	assign idx    = idlw_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.device_address <= idlw_pkg::DevAddrRst;
			cfg_q.command_byte   <= idlw_pkg::CmdByteRst;
			cfg_q.ready_timeout  <= idlw_pkg::TimeoutRst;
		end else if (wr_en) begin
			case (idx)
				idlw_pkg::REG_DEV_ADDR: cfg_q.device_address <= pwdata[7:0];
				idlw_pkg::REG_CMD_BYTE: cfg_q.command_byte   <= pwdata[7:0];
				idlw_pkg::REG_TIMEOUT:  cfg_q.ready_timeout  <= pwdata[idlw_pkg::WaitW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			idlw_pkg::REG_DEV_ADDR: prdata = {24'h0, cfg_q.device_address};
			idlw_pkg::REG_CMD_BYTE: prdata = {24'h0, cfg_q.command_byte};
			idlw_pkg::REG_TIMEOUT:  prdata = {16'h0, cfg_q.ready_timeout};
			default:                prdata = '0;
		endcase
	end

endmodule

// File: rtl/idlw_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idlw_seq
// Bus segment sequencer: state registers and the next-state and line logic.
// ----------------------------------------------------------------------------
module idlw_seq (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           step,
	input  logic                           opcode,
	input  logic [idlw_pkg::LevelW-1:0]    level,
	input  logic                           sda_in,
	input  idlw_pkg::cfg_t                 cfg,
	output idlw_pkg::res_t                 res
);

	logic                          active_q, active_d;
	idlw_pkg::seg_t                seg_q, seg_d;
	logic [3:0]                    bit_cnt_q, bit_cnt_d;
	logic [1:0]                    byte_cnt_q, byte_cnt_d;
	logic [7:0]                    shift_q, shift_d;
	logic [idlw_pkg::LevelW-1:0]   level_q, level_d;
	logic [idlw_pkg::WaitW-1:0]    wait_q, wait_d;
	logic                          nack_q, nack_d;
	logic                          done;
	idlw_pkg::status_t             status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			seg_q      <= idlw_pkg::SEG_IDLE;
			bit_cnt_q  <= '0;
			byte_cnt_q <= '0;
			shift_q    <= '0;
			level_q    <= '0;
			wait_q     <= '0;
			nack_q     <= 1'b0;
		end else if (step) begin
			active_q   <= active_d;
			seg_q      <= seg_d;
			bit_cnt_q  <= bit_cnt_d;
			byte_cnt_q <= byte_cnt_d;
			shift_q    <= shift_d;
			level_q    <= level_d;
			wait_q     <= wait_d;
			nack_q     <= nack_d;
		end
	end

	always_comb begin
		active_d   = active_q;
		seg_d      = seg_q;
		bit_cnt_d  = bit_cnt_q;
		byte_cnt_d = byte_cnt_q;
		shift_d    = shift_q;
		level_d    = level_q;
		wait_d     = wait_q;
		nack_d     = nack_q;
		done       = 1'b0;
		status     = idlw_pkg::ST_OK;

		if (opcode) begin
			if (!active_q) begin
				level_d    = level;
				active_d   = 1'b1;
				seg_d      = idlw_pkg::SEG_POLL;
				wait_d     = '0;
				nack_d     = 1'b0;
				bit_cnt_d  = '0;
				byte_cnt_d = '0;
				shift_d    = '0;
			end
		end else if (active_q) begin
			case (seg_q)
				idlw_pkg::SEG_POLL: begin
					if (sda_in) begin
						seg_d = idlw_pkg::SEG_START;
					end else begin
						wait_d = wait_q + 1'b1;
						if (wait_d == '0 || wait_d >= cfg.ready_timeout) begin
							active_d = 1'b0;
							seg_d    = idlw_pkg::SEG_IDLE;
							done     = 1'b1;
							status   = idlw_pkg::ST_NOT_RDY;
						end
					end
				end
				idlw_pkg::SEG_START: begin
					byte_cnt_d = '0;
					bit_cnt_d  = '0;
					shift_d    = idlw_pkg::byte_for(2'd0, cfg, level_q);
					seg_d      = idlw_pkg::SEG_BLO;
				end
				idlw_pkg::SEG_BLO: seg_d = idlw_pkg::SEG_BHI;
				idlw_pkg::SEG_BHI: begin
					shift_d   = {shift_q[6:0], 1'b0};
					bit_cnt_d = bit_cnt_q + 1'b1;
					seg_d     = bit_cnt_d[3] ? idlw_pkg::SEG_ALO : idlw_pkg::SEG_BLO;
				end
				idlw_pkg::SEG_ALO: seg_d = idlw_pkg::SEG_AHI;
				idlw_pkg::SEG_AHI: begin
					if (byte_cnt_q == 2'd0 && sda_in) begin
						nack_d = 1'b1;
					end
					seg_d = idlw_pkg::SEG_AHOLD;
				end
				idlw_pkg::SEG_AHOLD: begin
					if (byte_cnt_q == 2'd3) begin
						seg_d = idlw_pkg::SEG_P0;
					end else begin
						byte_cnt_d = byte_cnt_q + 1'b1;
						shift_d    = idlw_pkg::byte_for(byte_cnt_d, cfg, level_q);
						bit_cnt_d  = '0;
						seg_d      = idlw_pkg::SEG_BLO;
					end
				end
				idlw_pkg::SEG_P0: seg_d = idlw_pkg::SEG_P1;
				idlw_pkg::SEG_P1: begin
					active_d = 1'b0;
					seg_d    = idlw_pkg::SEG_IDLE;
					done     = 1'b1;
					status   = nack_q ? idlw_pkg::ST_NACK : idlw_pkg::ST_OK;
				end
				default: begin
					active_d = 1'b0;
					seg_d    = idlw_pkg::SEG_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res.busy_res = active_d;
		res.done_res = done;
		res.status   = status;
		res.scl      = 1'b1;
		res.sda_oe   = 1'b0;
		res.sda_out  = 1'b0;
		case (seg_d)
			idlw_pkg::SEG_START: begin
				res.sda_oe = 1'b1;
			end
			idlw_pkg::SEG_BLO: begin
				res.scl     = 1'b0;
				res.sda_oe  = 1'b1;
				res.sda_out = shift_d[7];
			end
			idlw_pkg::SEG_BHI: begin
				res.sda_oe  = 1'b1;
				res.sda_out = shift_d[7];
			end
			idlw_pkg::SEG_ALO: res.scl = 1'b0;
			idlw_pkg::SEG_P0: begin
				res.scl    = 1'b0;
				res.sda_oe = 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the I2C DAC level writer. Tick and request words
// go in on the stream input, bus line words are checked on the stream output
// against a cycle-free model of the sequencer or a typed word, and the three
// registers are written and read back over APB between phases while idle.
// ----------------------------------------------------------------------------
module testbench;
	import idlw_pkg::*;

	localparam int unsigned CycleLimit     = 400000;
	localparam int unsigned RandomPerPhase = 300;

	typedef struct packed {
		logic              op;
		logic [LevelW-1:0] lvl;
		logic              sda;
		logic              typed;
		logic [6:0]        res;
	} dir_row_t;

	logic             clk      = 1'b0;
	logic             arst_n   = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [15:0]      s_tdata  = '0;
	logic             s_tuser  = 1'b0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [7:0]       m_tdata;
	logic             psel     = 1'b0;
	logic             penable  = 1'b0;
	logic             pwrite   = 1'b0;
	logic [AddrW-1:0] paddr    = '0;
	logic [DataW-1:0] pwdata   = '0;
	logic [DataW-1:0] prdata;
	logic             pready;

	// Model of the sequencer state and its register copy.
	cfg_t              cfg          = '{DevAddrRst, CmdByteRst, TimeoutRst};
	logic              xfer_active  = 1'b0;
	seg_t              seg          = SEG_IDLE;
	logic [3:0]        bit_cnt      = '0;
	logic [1:0]        byte_cnt     = '0;
	logic [7:0]        shift_reg    = '0;
	logic [LevelW-1:0] held_lvl     = '0;
	logic [WaitW-1:0]  poll_count   = '0;
	logic              addr_nacked  = 1'b0;

	res_t        expected_words [$];
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit          tx_idle_on = 1'b1;
	bit          rx_idle_on = 1'b1;
	int unsigned rx_wait = 0;

	// Extremes, each operation, a request while busy and a bus-not-ready
	// failure, with timeout 2, address 0xff and command 0x00.
	dir_row_t dir_rows [0:13] = '{
		'{1'b0, 12'hfff, 1'b1, 1'b1, 7'h01},
		'{1'b0, 12'h000, 1'b0, 1'b1, 7'h01},
		'{1'b1, 12'hfff, 1'b0, 1'b1, 7'h09},
		'{1'b1, 12'h000, 1'b1, 1'b1, 7'h09},
		'{1'b0, 12'h000, 1'b0, 1'b0, 7'h00},
		'{1'b0, 12'hfff, 1'b0, 1'b1, 7'h31},
		'{1'b0, 12'hfff, 1'b1, 1'b1, 7'h01},
		'{1'b1, 12'h000, 1'b1, 1'b1, 7'h09},
		'{1'b0, 12'h000, 1'b1, 1'b0, 7'h00},
		'{1'b0, 12'h000, 1'b0, 1'b0, 7'h00},
		'{1'b0, 12'h000, 1'b1, 1'b0, 7'h00},
		'{1'b1, 12'habc, 1'b0, 1'b0, 7'h00},
		'{1'b0, 12'h000, 1'b0, 1'b0, 7'h00},
		'{1'b0, 12'hfff, 1'b1, 1'b0, 7'h00}
	};

	i2c_dac_level_writer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always #5 clk = ~clk;

	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(99);
		if (roll < 60) return 0;
		if (roll < 90) return $urandom_range(3, 1);
		return $urandom_range(40, 6);
	endfunction

	function automatic logic [7:0] frame_byte(input logic [1:0] n);
		case (n)
			2'd0:    return cfg.device_address;
			2'd1:    return cfg.command_byte;
			2'd2:    return held_lvl[11:4];
			default: return {held_lvl[3:0], 4'h0};
		endcase
	endfunction

	function automatic res_t dac_writer_next(input logic op, input logic [LevelW-1:0] lvl,
			input logic sda);
		res_t    r;
		logic    fin;
		status_t st;
		fin = 1'b0;
		st  = ST_OK;
		if (op) begin
			if (!xfer_active) begin
				held_lvl    = lvl;
				xfer_active = 1'b1;
				seg         = SEG_POLL;
				poll_count  = '0;
				addr_nacked = 1'b0;
				bit_cnt     = '0;
				byte_cnt    = '0;
				shift_reg   = '0;
			end
		end else if (xfer_active) begin
			case (seg)
				SEG_POLL: begin
					if (sda) begin
						seg = SEG_START;
					end else begin
						poll_count = poll_count + 1'b1;
						if (poll_count == '0 || poll_count >= cfg.ready_timeout) begin
							xfer_active = 1'b0;
							seg         = SEG_IDLE;
							fin         = 1'b1;
							st          = ST_NOT_RDY;
						end
					end
				end
				SEG_START: begin
					byte_cnt  = '0;
					bit_cnt   = '0;
					shift_reg = frame_byte(2'd0);
					seg       = SEG_BLO;
				end
				SEG_BLO: seg = SEG_BHI;
				SEG_BHI: begin
					shift_reg = shift_reg << 1;
					bit_cnt   = bit_cnt + 1'b1;
					if (bit_cnt >= 4'd8) seg = SEG_ALO;
					else seg = SEG_BLO;
				end
				SEG_ALO: seg = SEG_AHI;
				SEG_AHI: begin
					if (byte_cnt == 2'd0 && sda) addr_nacked = 1'b1;
					seg = SEG_AHOLD;
				end
				SEG_AHOLD: begin
					if (byte_cnt == 2'd3) begin
						seg = SEG_P0;
					end else begin
						byte_cnt  = byte_cnt + 1'b1;
						shift_reg = frame_byte(byte_cnt);
						bit_cnt   = '0;
						seg       = SEG_BLO;
					end
				end
				SEG_P0: seg = SEG_P1;
				SEG_P1: begin
					xfer_active = 1'b0;
					seg         = SEG_IDLE;
					fin         = 1'b1;
					st          = addr_nacked ? ST_NACK : ST_OK;
				end
				default: begin
					xfer_active = 1'b0;
					seg         = SEG_IDLE;
				end
			endcase
		end
		r     = '0;
		r.scl = 1'b1;
		case (seg)
			SEG_START: r.sda_oe = 1'b1;
			SEG_BLO: begin
				r.scl     = 1'b0;
				r.sda_oe  = 1'b1;
				r.sda_out = shift_reg[7];
			end
			SEG_BHI: begin
				r.sda_oe  = 1'b1;
				r.sda_out = shift_reg[7];
			end
			SEG_ALO: r.scl = 1'b0;
			SEG_P0: begin
				r.scl    = 1'b0;
				r.sda_oe = 1'b1;
			end
			default: ;
		endcase
		r.busy_res = xfer_active;
		r.done_res = fin;
		r.status   = st;
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic apb_cycle(input logic wr, input reg_idx_t idx, input logic [DataW-1:0] wdata,
			output logic [DataW-1:0] rdata);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= AddrW'({idx, 2'b00});
		pwdata  <= wdata;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		rdata = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_register(input reg_idx_t idx, input logic [DataW-1:0] value);
		logic [DataW-1:0] rd;
		logic [DataW-1:0] want;
		apb_cycle(1'b1, idx, value, rd);
		case (idx)
			REG_DEV_ADDR: begin
				cfg.device_address = value[7:0];
				want = DataW'(value[7:0]);
			end
			REG_CMD_BYTE: begin
				cfg.command_byte = value[7:0];
				want = DataW'(value[7:0]);
			end
			default: begin
				cfg.ready_timeout = value[WaitW-1:0];
				want = DataW'(value[WaitW-1:0]);
			end
		endcase
		apb_cycle(1'b0, idx, '0, rd);
		check_field(idx.name(), want, rd);
	endtask

	task automatic program_config(input logic [7:0] dev, input logic [7:0] cmd,
			input logic [WaitW-1:0] tmo);
		set_register(REG_DEV_ADDR, DataW'(dev));
		set_register(REG_CMD_BYTE, DataW'(cmd));
		set_register(REG_TIMEOUT, DataW'(tmo));
	endtask

	task automatic send_word(input logic op, input logic [LevelW-1:0] lvl, input logic sda,
			input logic typed, input logic [6:0] typed_res);
		res_t predicted;
		s_tuser  <= op;
		s_tdata  <= {3'b000, sda, lvl};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = dac_writer_next(op, lvl, sda);
		expected_words.push_back(typed ? res_t'(typed_res) : predicted);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(posedge clk); while (expected_words.size() != 0);
		@(negedge clk);
	endtask

	task automatic pace_sender(input logic pause);
		int unsigned gap;
		gap = tx_idle_on ? pick_gap() : 0;
		if (pause || gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
			if (pause) wait_drained();
		end
	endtask

	task automatic finish_transfer();
		while (xfer_active) begin
			send_word(1'b0, LevelW'($urandom), 1'($urandom), 1'b0, '0);
			pace_sender(1'b0);
		end
		pace_sender(1'b1);
	endtask

	task automatic run_phase(input int unsigned poll_high_pct);
		int unsigned     taken;
		logic            op;
		logic            sda;
		logic            ignored;
		logic [LevelW-1:0] lvl;
		taken = 0;
		while (taken < RandomPerPhase) begin
			op  = xfer_active ? ($urandom_range(99) < 4) : ($urandom_range(99) < 85);
			lvl = LevelW'($urandom);
			if (xfer_active && seg == SEG_POLL) sda = ($urandom_range(99) < poll_high_pct);
			else sda = 1'($urandom);
			ignored = (op == xfer_active);
			send_word(op, lvl, sda, 1'b0, '0);
			if (!ignored) taken++;
			pace_sender(!ignored && taken == RandomPerPhase / 2);
		end
		finish_transfer();
	endtask

	always @(negedge clk) begin
		if (rx_wait == 0 && rx_idle_on) rx_wait = pick_gap();
		if (rx_wait != 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[6:0]);
			if (expected_words.size() == 0) begin
				$error("unexpected result word %h", m_tdata);
				fail_count++;
			end else begin
				want = expected_words.pop_front();
				check_field("scl", want.scl, got.scl);
				check_field("sda_oe", want.sda_oe, got.sda_oe);
				check_field("sda_out", want.sda_out, got.sda_out);
				check_field("busy_res", want.busy_res, got.busy_res);
				check_field("done_res", want.done_res, got.done_res);
				check_field("status", want.status, got.status);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		program_config(8'hff, 8'h00, 16'd2);
		foreach (dir_rows[i]) begin
			send_word(dir_rows[i].op, dir_rows[i].lvl, dir_rows[i].sda, dir_rows[i].typed,
				dir_rows[i].res);
			pace_sender(1'b0);
		end
		finish_transfer();

		program_config(8'($urandom), 8'($urandom), 16'd1);
		run_phase(60);

		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		program_config(8'h00, 8'hff, 16'd0);
		run_phase(60);

		tx_idle_on = 1'b1;
		program_config(8'($urandom), 8'($urandom), 16'hffff);
		run_phase(70);

		tx_idle_on = 1'b0;
		rx_idle_on = 1'b1;
		program_config(8'($urandom), 8'($urandom), 16'($urandom_range(8, 2)));
		run_phase(75);

		tx_idle_on = 1'b1;
		program_config(8'($urandom), 8'($urandom), 16'd2000);
		run_phase(90);

		repeat (4) @(posedge clk);
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
